@@ src/desk_height_drive_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Desk height drive controller assertion macros
// Shared assertion forms for the checker of the desk height drive controller.
// ----------------------------------------------------------------------------
`ifndef DESK_HEIGHT_DRIVE_CONTROLLER_DEFINES_SVH
`define DESK_HEIGHT_DRIVE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DHDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/dhdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller package
// Types, codes and reset values shared by the controller modules.
// ----------------------------------------------------------------------------
package dhdc_pkg;

  localparam int unsigned HeightW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [HeightW-1:0] StopDistReset = 16'd10;
  localparam logic [HeightW-1:0] MaxJumpReset  = 16'd100;
  localparam logic [HeightW-1:0] TmoTicksReset = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STOP_DIST    = 3'd0,
    REG_TMO_EN       = 3'd1,
    REG_TMO_TICKS    = 3'd2,
    REG_MAX_JUMP     = 3'd3,
    REG_UP_PRESENT   = 3'd4,
    REG_DOWN_PRESENT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_STOP = 2'd2,
    KIND_TICK = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RAISE = 2'd1,
    OP_LOWER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_ARRIVED = 2'd1,
    CAUSE_TIMEOUT = 2'd2,
    CAUSE_REQUEST = 2'd3
  } cause_e;

  typedef struct packed {
    logic [HeightW-1:0] stop_dist;
    logic               tmo_en;
    logic [HeightW-1:0] tmo_ticks;
    logic [HeightW-1:0] max_jump;
    logic               up_present;
    logic               down_present;
  } cfg_t;

  typedef struct packed {
    cause_e             cause;
    logic               rejected;
    logic               updated;
    logic [HeightW-1:0] height;
    op_e                op;
    logic               down;
    logic               up;
  } res_t;

endpackage

@@ src/dhdc_cfg.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller configuration registers
// Holds the six setup registers written through the plain write port.
// ----------------------------------------------------------------------------
module dhdc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [dhdc_pkg::CfgIdxW-1:0] index_i,
  input  logic [dhdc_pkg::HeightW-1:0] data_i,
  output dhdc_pkg::cfg_t              cfg_o
);

  dhdc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (dhdc_pkg::cfg_reg_e'(index_i))
        dhdc_pkg::REG_STOP_DIST:    cfg_d.stop_dist    = data_i;
        dhdc_pkg::REG_TMO_EN:       cfg_d.tmo_en       = data_i[0];
        dhdc_pkg::REG_TMO_TICKS:    cfg_d.tmo_ticks    = data_i;
        dhdc_pkg::REG_MAX_JUMP:     cfg_d.max_jump     = data_i;
        dhdc_pkg::REG_UP_PRESENT:   cfg_d.up_present   = data_i[0];
        dhdc_pkg::REG_DOWN_PRESENT: cfg_d.down_present = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_dist    <= dhdc_pkg::StopDistReset;
      cfg_q.tmo_en       <= 1'b0;
      cfg_q.tmo_ticks    <= dhdc_pkg::TmoTicksReset;
      cfg_q.max_jump     <= dhdc_pkg::MaxJumpReset;
      cfg_q.up_present   <= 1'b1;
      cfg_q.down_present <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dhdc_core.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller core
// Frame parser, height filter and motion control state, updated once per item.
// ----------------------------------------------------------------------------
module dhdc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dhdc_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [1:0]                  kind_i,
  input  logic [dhdc_pkg::HeightW-1:0] value_i,
  output dhdc_pkg::res_t              res_o
);

  localparam logic [7:0] FrameMark = 8'd1;

  function automatic logic [dhdc_pkg::HeightW-1:0] abs_diff(
    input logic [dhdc_pkg::HeightW-1:0] a,
    input logic [dhdc_pkg::HeightW-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [1:0]                  fpos_d, fpos_q;
  logic [7:0]                  fhigh_d, fhigh_q;
  logic [dhdc_pkg::HeightW-1:0] height_d, height_q;
  logic [dhdc_pkg::HeightW-1:0] target_d, target_q;
  logic                        moving_d, moving_q;
  logic [dhdc_pkg::HeightW-1:0] elapsed_d, elapsed_q;
  logic                        up_d, up_q;
  logic                        down_d, down_q;
  dhdc_pkg::op_e               op_d, op_q;
  logic                        updated, rejected;
  dhdc_pkg::cause_e            cause;
  logic [7:0]                  byte_in;
  logic [dhdc_pkg::HeightW-1:0] frame_h;

  assign byte_in = value_i[7:0];
  assign frame_h = {fhigh_q, byte_in};

  always_comb begin
    fpos_d    = fpos_q;
    fhigh_d   = fhigh_q;
    height_d  = height_q;
    target_d  = target_q;
    moving_d  = moving_q;
    elapsed_d = elapsed_q;
    up_d      = up_q;
    down_d    = down_q;
    op_d      = op_q;
    updated   = 1'b0;
    rejected  = 1'b0;
    cause     = dhdc_pkg::CAUSE_NONE;

    unique case (dhdc_pkg::kind_e'(kind_i))
      dhdc_pkg::KIND_BYTE: begin
        if (fpos_q <= 2'd1) begin
          fpos_d = (byte_in == FrameMark) ? 2'(fpos_q + 2'd1) : 2'd0;
        end else if (fpos_q == 2'd2) begin
          fhigh_d = byte_in;
          fpos_d  = 2'd3;
        end else begin
          if (frame_h != height_q) begin
            if (height_q == '0 || abs_diff(frame_h, height_q) < cfg_i.max_jump) begin
              height_d = frame_h;
              updated  = 1'b1;
            end else begin
              rejected = 1'b1;
            end
          end
          fpos_d = 2'd0;
        end
      end
      dhdc_pkg::KIND_MOVE: begin
        if (abs_diff(value_i, height_q) >= cfg_i.stop_dist) begin
          if (value_i > height_q) begin
            if (cfg_i.up_present) begin
              up_d      = 1'b1;
              down_d    = 1'b0;
              op_d      = dhdc_pkg::OP_RAISE;
              target_d  = value_i;
              moving_d  = 1'b1;
              elapsed_d = '0;
            end
          end else if (cfg_i.down_present) begin
            up_d      = 1'b0;
            down_d    = 1'b1;
            op_d      = dhdc_pkg::OP_LOWER;
            target_d  = value_i;
            moving_d  = 1'b1;
            elapsed_d = '0;
          end
        end
      end
      dhdc_pkg::KIND_STOP: begin
        moving_d = 1'b0;
        up_d     = 1'b0;
        down_d   = 1'b0;
        op_d     = dhdc_pkg::OP_IDLE;
        cause    = dhdc_pkg::CAUSE_REQUEST;
      end
      dhdc_pkg::KIND_TICK: begin
        if (moving_q && elapsed_q != '1) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end
      default: ;
    endcase

    // Arrival and timeout are judged on the state this item leaves behind.
    if (moving_d) begin
      if (abs_diff(target_d, height_d) < cfg_i.stop_dist) begin
        moving_d = 1'b0;
        up_d     = 1'b0;
        down_d   = 1'b0;
        op_d     = dhdc_pkg::OP_IDLE;
        cause    = dhdc_pkg::CAUSE_ARRIVED;
      end else if (cfg_i.tmo_en && elapsed_d >= cfg_i.tmo_ticks) begin
        moving_d = 1'b0;
        up_d     = 1'b0;
        down_d   = 1'b0;
        op_d     = dhdc_pkg::OP_IDLE;
        cause    = dhdc_pkg::CAUSE_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpos_q    <= 2'd0;
      fhigh_q   <= '0;
      height_q  <= '0;
      target_q  <= '0;
      moving_q  <= 1'b0;
      elapsed_q <= '0;
      up_q      <= 1'b0;
      down_q    <= 1'b0;
      op_q      <= dhdc_pkg::OP_IDLE;
    end else if (step_i) begin
      fpos_q    <= fpos_d;
      fhigh_q   <= fhigh_d;
      height_q  <= height_d;
      target_q  <= target_d;
      moving_q  <= moving_d;
      elapsed_q <= elapsed_d;
      up_q      <= up_d;
      down_q    <= down_d;
      op_q      <= op_d;
    end
  end

  always_comb begin
    res_o.up       = up_d;
    res_o.down     = down_d;
    res_o.op       = op_d;
    res_o.height   = height_d;
    res_o.updated  = updated;
    res_o.rejected = rejected;
    res_o.cause    = cause;
  end

endmodule

@@ src/desk_height_drive_controller.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller
// Top level: input register, single-pass core, result register.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. An item is accepted into an
// input register, evaluated by the core and held in a result register. While
// the output is taken, a new item can be accepted every cycle; the rate is
// then one item per cycle, set by the single compare-and-update pass of the
// core on its state registers. The input register keeps accepting while a
// result waits to be taken as long as it is itself empty. Configuration
// registers are to be written only while no item is in flight; the block
// itself does not enforce this.
module desk_height_drive_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] value
  input  logic [1:0]                  s_axis_tuser,  // [1:0] kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] up_drive, [1] down_drive, [3:2] operation, [19:4] height,
  // [20] height_updated, [21] height_rejected, [23:22] stop_cause
  output logic [23:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [dhdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dhdc_pkg::HeightW-1:0] cfg_data_i
);

  dhdc_pkg::cfg_t               cfg;
  dhdc_pkg::res_t               res;
  logic                         in_valid_d, in_valid_q;
  logic [1:0]                   in_kind_q;
  logic [dhdc_pkg::HeightW-1:0] in_value_q;
  logic                         out_valid_d, out_valid_q;
  dhdc_pkg::res_t               out_res_q;
  logic                         advance, step, in_take;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q  <= s_axis_tuser;
      in_value_q <= s_axis_tdata;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  dhdc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  dhdc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (step),
    .kind_i  (in_kind_q),
    .value_i (in_value_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

endmodule

@@ src/dhdc_checker.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "desk_height_drive_controller_defines.svh"

module dhdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `DHDC_ASSERT_NOW(a_drive_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
  `DHDC_ASSERT_NOW(a_op_match, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[0] == (m_axis_tdata[3:2] == dhdc_pkg::OP_RAISE)) && (m_axis_tdata[1] == (m_axis_tdata[3:2] == dhdc_pkg::OP_LOWER)) && (m_axis_tdata[3:2] != 2'd3))
  `DHDC_ASSERT_NOW(a_stop_idle, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[23:22] != dhdc_pkg::CAUSE_NONE), m_axis_tdata[3:0] == 4'd0)
  `DHDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind desk_height_drive_controller dhdc_checker u_dhdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_desk_height_drive_controller.sv @@
// ----------------------------------------------------------------------------
// Desk height drive controller testbench
// Sends received bytes, move and stop requests and millisecond ticks through
// the input stream, predicts every result item from a behavioral copy of the
// frame parser and motion logic, and checks the output stream field by field
// under random idling, a long receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module tb_desk_height_drive_controller;
  import dhdc_pkg::*;

  localparam int CycleLimit = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;  // [15:0] value
  logic [1:0]          s_axis_tuser;  // [1:0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] up_drive, [1] down_drive, [3:2] operation, [19:4] height,
  // [20] height_updated, [21] height_rejected, [23:22] stop_cause
  logic [23:0]         m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [HeightW-1:0]  cfg_data_i;

  desk_height_drive_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Register copies.
  logic [15:0] stop_dist  = StopDistReset;
  logic        tmo_on     = 1'b0;
  logic [15:0] tmo_limit  = TmoTicksReset;
  logic [15:0] jump_limit = MaxJumpReset;
  logic        has_up     = 1'b1;
  logic        has_down   = 1'b1;

  // Controller state copies.
  logic [1:0]  frame_pos  = 2'd0;
  logic [7:0]  frame_hi   = 8'd0;
  logic [15:0] ht_now     = 16'd0;
  logic [15:0] ht_target  = 16'd0;
  logic        in_motion  = 1'b0;
  logic [15:0] motion_ms  = 16'd0;
  logic        drive_up   = 1'b0;
  logic        drive_down = 1'b0;
  op_e         motion_op  = OP_IDLE;

  res_t pending_drive_outputs[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  items_sent    = 0;
  int  cycle_count   = 0;
  int  hold_off_left = 0;
  bit  no_idle       = 1'b0;
  int  heights_taken = 0;
  int  heights_refused = 0;
  int  stops_by_cause [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] height_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void halt_desk();
    in_motion  = 1'b0;
    drive_up   = 1'b0;
    drive_down = 1'b0;
    motion_op  = OP_IDLE;
  endfunction

  function automatic res_t advance_desk(kind_e k, logic [15:0] v);
    res_t        r;
    logic [15:0] h;
    logic        go;
    r  = '0;
    go = 1'b0;
    case (k)
      KIND_BYTE: begin
        if (frame_pos <= 2'd1) begin
          frame_pos = (v[7:0] == 8'd1) ? frame_pos + 2'd1 : 2'd0;
        end else if (frame_pos == 2'd2) begin
          frame_hi  = v[7:0];
          frame_pos = 2'd3;
        end else begin
          h = {frame_hi, v[7:0]};
          if (h != ht_now) begin
            if (ht_now == 16'd0 || height_gap(h, ht_now) < jump_limit) begin
              ht_now    = h;
              r.updated = 1'b1;
            end else begin
              r.rejected = 1'b1;
            end
          end
          frame_pos = 2'd0;
        end
      end
      KIND_MOVE: begin
        if (height_gap(v, ht_now) >= stop_dist) begin
          if (v > ht_now) begin
            if (has_up) begin
              drive_up   = 1'b1;
              drive_down = 1'b0;
              motion_op  = OP_RAISE;
              go         = 1'b1;
            end
          end else if (has_down) begin
            drive_down = 1'b1;
            drive_up   = 1'b0;
            motion_op  = OP_LOWER;
            go         = 1'b1;
          end
          if (go) begin
            ht_target = v;
            in_motion = 1'b1;
            motion_ms = 16'd0;
          end
        end
      end
      KIND_STOP: begin
        halt_desk();
        r.cause = CAUSE_REQUEST;
      end
      KIND_TICK: begin
        if (in_motion && motion_ms != 16'hFFFF) motion_ms = motion_ms + 16'd1;
      end
    endcase
    if (in_motion) begin
      if (height_gap(ht_target, ht_now) < stop_dist) begin
        halt_desk();
        r.cause = CAUSE_ARRIVED;
      end else if (tmo_on && motion_ms >= tmo_limit) begin
        halt_desk();
        r.cause = CAUSE_TIMEOUT;
      end
    end
    r.up     = drive_up;
    r.down   = drive_down;
    r.op     = motion_op;
    r.height = ht_now;
    return r;
  endfunction

  // Heights near the current one, near the target, at the stopping and jump
  // boundaries, at the extremes, or anywhere.
  function automatic logic [15:0] pick_height();
    int          sel;
    int          span;
    logic [15:0] off;
    sel = $urandom_range(0, 99);
    if (sel < 12) return ht_now;
    if (sel < 27 && in_motion) return ht_target - 16'd12 + 16'($urandom_range(0, 24));
    if (sel < 45) begin
      off = ($urandom_range(0, 1) ? stop_dist : jump_limit) - 16'd1 +
            16'($urandom_range(0, 2));
      return $urandom_range(0, 1) ? ht_now + off : ht_now - off;
    end
    if (sel < 80) begin
      span = $urandom_range(0, 1) ? 40 : 300;
      return ht_now - 16'(span) + 16'($urandom_range(0, 2 * span));
    end
    if (sel < 90) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_item(kind_e k, logic [15:0] v);
    res_t want;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tuser  = k;
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_desk(k, v);
    pending_drive_outputs.push_back(want);
    items_sent++;
    heights_taken   += want.updated;
    heights_refused += want.rejected;
    stops_by_cause[want.cause]++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_frame(logic [15:0] h);
    send_item(KIND_BYTE, {8'($urandom), 8'd1});
    send_item(KIND_BYTE, {8'($urandom), 8'd1});
    send_item(KIND_BYTE, {8'($urandom), h[15:8]});
    send_item(KIND_BYTE, {8'($urandom), h[7:0]});
  endtask

  task automatic wait_idle();
    while (pending_drive_outputs.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_STOP_DIST:    stop_dist  = data;
      REG_TMO_EN:       tmo_on     = data[0];
      REG_TMO_TICKS:    tmo_limit  = data;
      REG_MAX_JUMP:     jump_limit = data;
      REG_UP_PRESENT:   has_up     = data[0];
      REG_DOWN_PRESENT: has_down   = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] sd, logic te, logic [15:0] tt,
                                logic [15:0] mj, logic up, logic dn);
    wait_idle();
    write_reg(REG_STOP_DIST, sd);
    write_reg(REG_TMO_EN, {15'd0, te});
    write_reg(REG_TMO_TICKS, tt);
    write_reg(REG_MAX_JUMP, mj);
    write_reg(REG_UP_PRESENT, {15'd0, up});
    write_reg(REG_DOWN_PRESENT, {15'd0, dn});
  endtask

  task automatic test_frame_parsing();
    send_item(KIND_BYTE, 16'hFF01);
    send_item(KIND_BYTE, 16'h0007);
    send_frame(16'h0100);
    send_frame(16'h0163);
    send_frame(16'h01C7);
  endtask

  task automatic test_move_and_stop();
    send_item(KIND_MOVE, 16'd365);
    send_item(KIND_MOVE, 16'd346);
    send_item(KIND_MOVE, 16'd0);
    send_item(KIND_STOP, 16'hFFFF);
    send_item(KIND_STOP, 16'h0000);
    send_item(KIND_MOVE, 16'hFFFF);
    send_item(KIND_MOVE, 16'd400);
    send_frame(16'd395);
  endtask

  task automatic test_timeout_and_drives();
    apply_settings(16'd10, 1'b1, 16'd0, MaxJumpReset, 1'b0, 1'b1);
    send_item(KIND_MOVE, 16'd1000);
    send_item(KIND_MOVE, 16'd0);
    apply_settings(16'd10, 1'b1, 16'd2, MaxJumpReset, 1'b1, 1'b1);
    send_item(KIND_MOVE, 16'd1000);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'hFFFF);
  endtask

  // Ticks count only while moving, and the timeout fires on the tick that
  // brings the elapsed time up to the limit.
  task automatic test_tick_counting();
    no_idle = 1'b1;
    apply_settings(16'd10, 1'b0, 16'd25, MaxJumpReset, 1'b1, 1'b1);
    send_item(KIND_STOP, 16'h0000);
    repeat (4) send_item(KIND_TICK, 16'($urandom));
    send_item(KIND_MOVE, ht_now ^ 16'h8000);
    repeat (24) send_item(KIND_TICK, 16'($urandom));
    apply_settings(16'd10, 1'b1, 16'd25, MaxJumpReset, 1'b1, 1'b1);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'h0000);
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    apply_settings(16'd5, 1'b1, 16'd20, 16'd500, 1'b1, 1'b1);
    hold_off_left = 60;
    repeat (24) send_item(kind_e'($urandom_range(0, 3)), 16'($urandom));
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic random_action();
    int          pick;
    logic [15:0] h;
    pick = $urandom_range(0, 99);
    h    = pick_height();
    if (pick < 35) begin
      send_frame(h);
    end else if (pick < 50) begin
      send_item(KIND_MOVE, h);
    end else if (pick < 55) begin
      send_item(KIND_STOP, 16'($urandom));
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) send_item(KIND_TICK, 16'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: send_item(KIND_BYTE, 16'($urandom));
        1: begin
          repeat ($urandom_range(1, 2)) send_item(KIND_BYTE, {8'($urandom), 8'd1});
          send_item(KIND_BYTE, 16'($urandom));
        end
        default: begin
          send_item(KIND_BYTE, {8'($urandom), 8'd1});
          send_item(KIND_BYTE, {8'($urandom), 8'd1});
          send_item(KIND_BYTE, {8'($urandom), h[15:8]});
          send_item(kind_e'($urandom_range(1, 3)), pick_height());
          send_item(KIND_BYTE, {8'($urandom), h[7:0]});
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int first;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(16'd10, 1'b0, 16'd0, 16'd100, 1'b1, 1'b1);
        1: apply_settings(16'd0, 1'b1, 16'($urandom_range(3, 20)), 16'hFFFF, 1'b1, 1'b1);
        2: apply_settings(16'hFFFF, 1'b0, 16'hFFFF, 16'd0, 1'b1, 1'b1);
        3: apply_settings(16'($urandom_range(1, 50)), 1'b1, 16'($urandom_range(0, 10)),
                          16'($urandom_range(20, 500)), 1'b0, 1'b1);
        4: apply_settings(16'($urandom_range(1, 50)), 1'b1, 16'hFFFF,
                          16'($urandom_range(20, 500)), 1'b1, 1'b0);
        5: apply_settings(16'd10, 1'b0, 16'd0, 16'd300, 1'b0, 1'b0);
        6: apply_settings($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
                          1'($urandom), 16'($urandom_range(0, 30)),
                          $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600)),
                          1'($urandom), 1'($urandom));
        default: apply_settings(16'd10, 1'b1, 16'd30, 16'd200, 1'b1, 1'b1);
      endcase
      no_idle = (ph == 3) || (ph == 7);
      first   = items_sent;
      while (items_sent - first < 70) random_action();
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endtask

  always @(posedge clk_i) begin : output_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata);
      if (pending_drive_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result item %h arrived with none expected", m_axis_tdata);
      end else begin
        want = pending_drive_outputs.pop_front();
        check_field("up_drive", want.up, got.up);
        check_field("down_drive", want.down, got.down);
        check_field("operation", want.op, got.op);
        check_field("height", want.height, got.height);
        check_field("height_updated", want.updated, got.updated);
        check_field("height_rejected", want.rejected, got.rejected);
        check_field("stop_cause", want.cause, got.cause);
        results_seen++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready = 1'b0;
        hold_off_left--;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding",
               pending_drive_outputs.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = KIND_BYTE;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_STOP_DIST;
    cfg_data_i    = 16'd0;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_frame_parsing();
    test_move_and_stop();
    test_timeout_and_drives();
    test_tick_counting();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (pending_drive_outputs.size() != 0) begin
      mismatches += pending_drive_outputs.size();
      $display("%0d expected results never arrived", pending_drive_outputs.size());
    end
    $display("Sent %0d items and checked %0d results over frames, moves, stops, ticks",
             items_sent, results_seen);
    $display("Heights taken %0d, refused %0d; stops: arrival %0d, timeout %0d, request %0d",
             heights_taken, heights_refused, stops_by_cause[CAUSE_ARRIVED],
             stops_by_cause[CAUSE_TIMEOUT], stops_by_cause[CAUSE_REQUEST]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
